// ===== rtl/lmsaf_pkg.sv =====
// Shared types, constants and sequencer codes for the LMS adaptive FIR unit.
// No dependencies; every other file imports this package.
`default_nettype none

package lmsaf_pkg;

	localparam int TAPS  = 32;
	localparam int IDX_W = $clog2(TAPS);
	localparam int CNT_W = $clog2(TAPS + 1);

	localparam int SMP_W  = 16;               // Q1.15 samples
	localparam int WGT_W  = 32;               // Q2.30 weights
	localparam int STEP_W = 16;               // Q0.16 step size
	localparam int MA_W   = 32;               // multiplier operand a
	localparam int MB_W   = 17;               // multiplier operand b
	localparam int PROD_W = MA_W + MB_W;
	localparam int ACC_W  = PROD_W + IDX_W;
	localparam int Y_SHIFT = 30;              // Q3.45 -> Q1.15
	localparam int D_SHIFT = 16;              // Q2.46 -> Q2.30
	localparam int WSUM_W  = WGT_W + 2;

	localparam logic [STEP_W-1:0] STEP_RESET = 16'd218;
	localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7fff;
	localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;
	localparam logic signed [WGT_W-1:0] WGT_MAX = 32'sh7fff_ffff;
	localparam logic signed [WGT_W-1:0] WGT_MIN = 32'sh8000_0000;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_STEP_SIZE = 1'b0;

	typedef logic signed [SMP_W-1:0] smp_t;
	typedef logic signed [WGT_W-1:0] wgt_t;
	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DOT,
		S_ROUND,
		S_ERR,
		S_MUE,
		S_LAT,
		S_UPD,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		OP_DOT,
		OP_MUE,
		OP_UPD
	} op_sel_t;

	typedef struct packed {
		logic             in_ready;
		logic             issue;
		op_sel_t          op_sel;
		logic             acc_en;
		logic             round_en;
		logic             err_en;
		logic             lat_en;
		logic             wr_en;
		logic             done;
		logic [IDX_W-1:0] ridx;
		logic [IDX_W-1:0] widx;
	} ctl_t;

endpackage

`default_nettype wire

// ===== rtl/lmsaf_if.sv =====
// Handshake channels of the LMS adaptive FIR unit: sample items in, result items out.
// Depends on lmsaf_pkg.
`default_nettype none

interface lmsaf_in_if import lmsaf_pkg::*; ();
	logic valid;
	logic ready;
	smp_t sample_in;
	smp_t desired_in;

	modport source (output valid, output sample_in, output desired_in, input ready);
	modport sink (input valid, input sample_in, input desired_in, output ready);
endinterface

interface lmsaf_out_if import lmsaf_pkg::*; ();
	logic valid;
	logic ready;
	smp_t filter_out;
	smp_t error_out;
	logic saturated;

	modport source (output valid, output filter_out, output error_out, output saturated,
		input ready);
	modport sink (input valid, input filter_out, input error_out, input saturated,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/lmsaf_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on lmsaf_pkg.
`default_nettype none

module lmsaf_mul import lmsaf_pkg::*; (
	input  wire                      clk,
	input  wire                      en,
	input  wire logic signed [MA_W-1:0]   a,
	input  wire logic signed [MB_W-1:0]   b,
	output logic signed [PROD_W-1:0] p
);

	logic signed [PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= PROD_W'(a) * PROD_W'(b);
		end
	end

	assign p = p_q;

endmodule

`default_nettype wire

// ===== rtl/lmsaf_apb.sv =====
// APB-style configuration register file: holds the step size.
// Depends on lmsaf_pkg.
`default_nettype none

module lmsaf_apb import lmsaf_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire [PADDR_W-1:0]  paddr,
	input  wire [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output step_t              step_size
);

	step_t step_q;
	logic [REG_IDX_W-1:0] reg_idx;

	assign reg_idx = paddr[PADDR_W-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (psel && penable && pwrite && reg_idx == REG_STEP_SIZE) begin
			step_q <= pwdata[STEP_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_STEP_SIZE) begin
			prdata = {{(PDATA_W-STEP_W){1'b0}}, step_q};
		end
	end

	assign step_size = step_q;

endmodule

`default_nettype wire

// ===== rtl/lmsaf_seq.sv =====
// Sequencer: dot-product pass, rounding, step-times-error, weight-update pass.
// Depends on lmsaf_pkg; drives the datapath through a ctl_t bundle.
`default_nettype none

module lmsaf_seq import lmsaf_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_fire,
	input  wire  out_free,
	output ctl_t ctl
);

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] cnt_m1;

	assign cnt_m1 = cnt_q - CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			S_IDLE: begin
				cnt_d = '0;
				if (in_fire) begin
					state_d = S_DOT;
				end
			end
			S_DOT: begin
				if (cnt_q == CNT_W'(TAPS)) begin
					cnt_d   = '0;
					state_d = S_ROUND;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			S_ROUND: state_d = S_ERR;
			S_ERR:   state_d = S_MUE;
			S_MUE:   state_d = S_LAT;
			S_LAT:   state_d = S_UPD;
			S_UPD: begin
				if (cnt_q == CNT_W'(TAPS)) begin
					cnt_d   = '0;
					state_d = S_DONE;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	// product of tap k is issued at count k and consumed in the next cycle, from the multiplier register
	always_comb begin
		ctl          = '0;
		ctl.op_sel   = OP_DOT;
		ctl.ridx     = cnt_q[IDX_W-1:0];
		ctl.widx     = cnt_m1[IDX_W-1:0];
		case (state_q)
			S_IDLE: ctl.in_ready = 1'b1;
			S_DOT: begin
				ctl.issue  = (cnt_q != CNT_W'(TAPS));
				ctl.acc_en = (cnt_q != '0);
			end
			S_ROUND: ctl.round_en = 1'b1;
			S_ERR:   ctl.err_en = 1'b1;
			S_MUE: begin
				ctl.issue  = 1'b1;
				ctl.op_sel = OP_MUE;
			end
			S_LAT: ctl.lat_en = 1'b1;
			S_UPD: begin
				ctl.op_sel = OP_UPD;
				ctl.issue  = (cnt_q != CNT_W'(TAPS));
				ctl.wr_en  = (cnt_q != '0);
			end
			S_DONE: ctl.done = 1'b1;
			default: ctl.in_ready = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/lms_adaptive_fir_unit.sv =====
// Channel     Dir  Payload                                   Handshake
// sample_ch   in   sample_in, desired_in (Q1.15)             valid/ready
// result_ch   out  filter_out, error_out (Q1.15), saturated  valid/ready
// apb         cfg  step_size at byte address 0               psel/penable, pready=1
//
// Items are accepted only in the idle state, so sample_ch takes a new item only once the
// last one is through. The single shared multiplier sets this:
// one dot-product pass, one step-times-error product, one weight-update pass. Reset
// clears the tap line and weights and loads step_size with 218. A result waiting on
// result_ch holds the block in its final state; the next item is taken once the result
// register frees.
// Depends on lmsaf_pkg, lmsaf_if, lmsaf_mul, lmsaf_apb, lmsaf_seq.
`default_nettype none

module lms_adaptive_fir_unit import lmsaf_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	lmsaf_in_if.sink           sample_ch,
	lmsaf_out_if.source        result_ch,
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire [PADDR_W-1:0]  paddr,
	input  wire [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	ctl_t  ctl;
	step_t step_size;
	logic  in_fire, out_free, out_load;

	smp_t tap_q [TAPS];
	wgt_t wgt_q [TAPS];
	smp_t d_q, y_q, e_q;
	logic sat_q;
	logic signed [MA_W-1:0]   mue_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [MA_W-1:0]   mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [PROD_W-1:0] prod;

	logic signed [ACC_W-1:0]  rnd_sum, rnd_sh;
	logic                     y_fit;
	smp_t                     y_new;
	logic [SMP_W:0]           e_wide;
	logic                     e_fit;
	smp_t                     e_new;
	logic signed [PROD_W-1:0] dsum, dsh;
	logic signed [WSUM_W-1:0] wsum;
	logic                     w_fit;
	wgt_t                     w_new;

	smp_t out_y_q, out_e_q;
	logic out_sat_q, out_valid_q;

	lmsaf_apb u_apb (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.step_size (step_size)
	);

	lmsaf_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.out_free (out_free),
		.ctl      (ctl)
	);

	lmsaf_mul u_mul (
		.clk (clk),
		.en  (ctl.issue),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	assign sample_ch.ready = ctl.in_ready;
	assign in_fire  = sample_ch.valid && ctl.in_ready;
	assign out_free = !out_valid_q || result_ch.ready;
	assign out_load = ctl.done && out_free;

	always_comb begin
		case (ctl.op_sel)
			OP_MUE: begin
				mul_a = {{(MA_W-SMP_W){e_q[SMP_W-1]}}, e_q};
				mul_b = {1'b0, step_size};
			end
			OP_UPD: begin
				mul_a = mue_q;
				mul_b = {tap_q[ctl.ridx][SMP_W-1], tap_q[ctl.ridx]};
			end
			default: begin
				mul_a = wgt_q[ctl.ridx];
				mul_b = {tap_q[ctl.ridx][SMP_W-1], tap_q[ctl.ridx]};
			end
		endcase
	end

	// output: round half up from Q3.45, clip to Q1.15
	assign rnd_sum = acc_q + (ACC_W'(1) <<< (Y_SHIFT - 1));
	assign rnd_sh  = rnd_sum >>> Y_SHIFT;
	assign y_fit   = (&rnd_sh[ACC_W-1:SMP_W-1]) || !(|rnd_sh[ACC_W-1:SMP_W-1]);
	assign y_new   = y_fit ? rnd_sh[SMP_W-1:0] : (rnd_sh[ACC_W-1] ? SMP_MIN : SMP_MAX);

	assign e_wide = {d_q[SMP_W-1], d_q} - {y_q[SMP_W-1], y_q};
	assign e_fit  = (e_wide[SMP_W] == e_wide[SMP_W-1]);
	assign e_new  = e_fit ? e_wide[SMP_W-1:0] : (e_wide[SMP_W] ? SMP_MIN : SMP_MAX);

	// weight update: round half up from Q2.46, add, clip to 32 bits
	assign dsum  = prod + (PROD_W'(1) <<< (D_SHIFT - 1));
	assign dsh   = dsum >>> D_SHIFT;
	assign wsum  = {{2{wgt_q[ctl.widx][WGT_W-1]}}, wgt_q[ctl.widx]} + dsh[WSUM_W-1:0];
	assign w_fit = (&wsum[WSUM_W-1:WGT_W-1]) || !(|wsum[WSUM_W-1:WGT_W-1]);
	assign w_new = w_fit ? wsum[WGT_W-1:0] : (wsum[WSUM_W-1] ? WGT_MIN : WGT_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAPS; k++) begin
				tap_q[k] <= '0;
				wgt_q[k] <= '0;
			end
		end else begin
			if (in_fire) begin
				tap_q[0] <= sample_ch.sample_in;
				for (int k = 1; k < TAPS; k++) begin
					tap_q[k] <= tap_q[k-1];
				end
			end
			if (ctl.wr_en) begin
				wgt_q[ctl.widx] <= w_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			d_q   <= sample_ch.desired_in;
			acc_q <= '0;
			sat_q <= 1'b0;
		end else begin
			if (ctl.acc_en) begin
				acc_q <= acc_q + {{IDX_W{prod[PROD_W-1]}}, prod};
			end
			if (ctl.round_en) begin
				y_q <= y_new;
				if (!y_fit) begin
					sat_q <= 1'b1;
				end
			end
			if (ctl.err_en) begin
				e_q <= e_new;
				if (!e_fit) begin
					sat_q <= 1'b1;
				end
			end
			if (ctl.wr_en && !w_fit) begin
				sat_q <= 1'b1;
			end
		end
		if (ctl.lat_en) begin
			mue_q <= prod[MA_W-1:0];
		end
		if (out_load) begin
			out_y_q   <= y_q;
			out_e_q   <= e_q;
			out_sat_q <= sat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_ch.valid      = out_valid_q;
	assign result_ch.filter_out = out_y_q;
	assign result_ch.error_out  = out_e_q;
	assign result_ch.saturated  = out_sat_q;

endmodule

`default_nettype wire
